FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the obstacle search RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// invariant
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

FILE: rtl/onir_pkg.sv
// ----------------------------------------------------------------------------
// onir_pkg
// Types and constants of the nearest obstacle search block.
// ----------------------------------------------------------------------------
package onir_pkg;

    localparam int MAX_OBSTACLES_DEF = 64;
    localparam int KEEP_NEAREST_DEF  = 3;

    localparam int COORD_W = 16;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int DIST_W  = PROD_W + 1;
    localparam int ID_W    = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_SEARCH_RADIUS  = 1'b0;
    localparam logic REG_OBSTACLE_COUNT = 1'b1;

    localparam logic [1:0] DU_LIMIT = 2'd0;
    localparam logic [1:0] DU_X     = 2'd1;
    localparam logic [1:0] DU_Y     = 2'd2;

    typedef struct packed {
        logic                      operation;
        logic [ID_W-1:0]           entry_index;
        logic signed [COORD_W-1:0] obstacle_x;
        logic signed [COORD_W-1:0] obstacle_y;
        logic [COORD_W-1:0]        obstacle_radius;
        logic signed [COORD_W-1:0] position_x;
        logic signed [COORD_W-1:0] position_y;
    } in_item_t;

    typedef struct packed {
        logic                      found;
        logic [ID_W-1:0]           near_id;
        logic signed [COORD_W-1:0] near_x;
        logic signed [COORD_W-1:0] near_y;
        logic [COORD_W-1:0]        near_radius;
        logic                      last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COORD_W-1:0]        radius;
    } entry_t;

    typedef struct packed {
        logic [DIST_W-1:0]         dist_sq;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COORD_W-1:0]        radius;
    } cand_t;

    typedef struct packed {
        logic       en;
        logic [1:0] mode;
    } du_ctrl_t;

endpackage

FILE: rtl/onir_table.sv
// ----------------------------------------------------------------------------
// onir_table
// Obstacle table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module onir_table #(
    parameter int DEPTH = onir_pkg::MAX_OBSTACLES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  onir_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output onir_pkg::entry_t rd_data
);

    onir_pkg::entry_t mem [DEPTH];
    onir_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/onir_dist_unit.sv
// ----------------------------------------------------------------------------
// onir_dist_unit
// Shared 16x16 squarer with accumulator: squared limit, then dx^2 + dy^2.
// ----------------------------------------------------------------------------
module onir_dist_unit (
    input  logic                               clk,
    input  onir_pkg::du_ctrl_t                 ctrl,
    input  logic [onir_pkg::COORD_W-1:0]       radius,
    input  logic signed [onir_pkg::COORD_W-1:0] pos_x,
    input  logic signed [onir_pkg::COORD_W-1:0] pos_y,
    input  onir_pkg::entry_t                   entry,
    output logic [onir_pkg::PROD_W-1:0]        limit,
    output logic [onir_pkg::DIST_W-1:0]        dist_sq
);

    localparam int CW = onir_pkg::COORD_W;
    localparam int PW = onir_pkg::PROD_W;

    logic signed [CW:0]               diff;
    logic signed [CW:0]               mag_wide;
    logic [CW-1:0]                    operand;
    logic [onir_pkg::PROD_W-1:0]      prod;
    logic [onir_pkg::PROD_W-1:0]      limit_reg;
    logic [onir_pkg::DIST_W-1:0]      dist_reg;

    always_comb
    begin
        diff = '0;
        unique case (ctrl.mode)
            onir_pkg::DU_X: diff = {entry.x[CW-1], entry.x} - {pos_x[CW-1], pos_x};
            onir_pkg::DU_Y: diff = {entry.y[CW-1], entry.y} - {pos_y[CW-1], pos_y};
            default:        diff = '0;
        endcase
        mag_wide = diff[CW] ? -diff : diff;
        operand  = (ctrl.mode == onir_pkg::DU_LIMIT) ? radius : mag_wide[CW-1:0];
        prod     = PW'(operand) * PW'(operand);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            unique case (ctrl.mode)
                onir_pkg::DU_LIMIT: limit_reg <= prod;
                onir_pkg::DU_X:     dist_reg  <= {1'b0, prod};
                onir_pkg::DU_Y:     dist_reg  <= dist_reg + {1'b0, prod};
                default:            dist_reg  <= dist_reg;
            endcase
        end
    end

    assign limit   = limit_reg;
    assign dist_sq = dist_reg;

endmodule

FILE: rtl/onir_rank.sv
// ----------------------------------------------------------------------------
// onir_rank
// Sorted list of the nearest candidates, one insertion per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onir_rank #(
    parameter int KEEP  = onir_pkg::KEEP_NEAREST_DEF,
    parameter int IDX_W = onir_pkg::ID_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 insert,
    input  onir_pkg::cand_t      cand,
    input  logic [IDX_W-1:0]     cand_idx,
    output onir_pkg::cand_t      best [KEEP],
    output logic [IDX_W-1:0]     best_idx [KEEP],
    output logic [KEEP-1:0]      valid
);

    onir_pkg::cand_t    best_reg [KEEP];
    onir_pkg::cand_t    best_next [KEEP];
    logic [IDX_W-1:0]   idx_reg [KEEP];
    logic [IDX_W-1:0]   idx_next [KEEP];
    logic [KEEP-1:0]    valid_reg;
    logic [KEEP-1:0]    valid_next;
    logic [KEEP-1:0]    ins;
    logic [KEEP-1:0]    ins_prev;
    logic [KEEP:0]      valid_inc;

    // later candidates carry higher indexes, so full ties never move ahead
    function automatic logic goes_before(onir_pkg::cand_t a, onir_pkg::cand_t b);
        logic r;
        if (a.dist_sq != b.dist_sq)
            r = a.dist_sq < b.dist_sq;
        else if (a.x != b.x)
            r = a.x < b.x;
        else
            r = a.y < b.y;
        return r;
    endfunction

    always_comb
    begin
        for (int j = 0; j < KEEP; j++)
        begin
            ins[j] = !valid_reg[j] || goes_before(cand, best_reg[j]);
        end
        ins_prev   = ins << 1;
        valid_next = valid_reg | (ins & ((valid_reg << 1) | KEEP'(1)));
        best_next  = best_reg;
        idx_next   = idx_reg;
        for (int j = 0; j < KEEP; j++)
        begin
            if (ins[j] && !ins_prev[j])
            begin
                best_next[j] = cand;
                idx_next[j]  = cand_idx;
            end
        end
        for (int j = 1; j < KEEP; j++)
        begin
            if (ins[j] && ins_prev[j])
            begin
                best_next[j] = best_reg[j-1];
                idx_next[j]  = idx_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (insert)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert && !clear)
        begin
            best_reg <= best_next;
            idx_reg  <= idx_next;
        end
    end

    assign best     = best_reg;
    assign best_idx = idx_reg;
    assign valid    = valid_reg;

    assign valid_inc = {1'b0, valid_reg} + {{KEEP{1'b0}}, 1'b1};

    `ASSERT_ALWAYS(a_valid_packed, clk, rst_n, $onehot(valid_inc), "rank valid bits not packed")

endmodule

FILE: rtl/nearest_obstacles_in_radius_core.sv
// ----------------------------------------------------------------------------
// nearest_obstacles_in_radius_core
// Keeps a table of circular obstacles and reports the nearest ones in range.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall / item): a load transfer writes one
// table slot and gives no result; the next item can follow in the next cycle.
// A query transfer scans the first obstacle_count entries with one shared
// squarer: the LIMIT state squares the search radius and issues the first
// table read, then each entry takes the MULX (dx^2), MULY (dy^2 plus
// accumulate) and CMP (compare and insert) states. The first result is
// registered in the EMIT state; the others follow one per cycle while the
// receiver does not stall, on the output channel (result_valid /
// result_stall / result): up to KEEP_NEAREST of them in ascending distance,
// the final one flagged last; an empty query gives one result with found low.
// item_stall is high from a query transfer until its final result has been
// loaded into the output register. A stalled receiver holds the result
// register and the scan waits there. Reset clears the control state, sets
// the search radius to 1280 and obstacle_count to 0; table contents are
// undefined until loaded. The user issues configuration writes (cfg_wr_en)
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_obstacles_in_radius_core #(
    parameter int MAX_OBSTACLES = onir_pkg::MAX_OBSTACLES_DEF,
    parameter int KEEP_NEAREST  = onir_pkg::KEEP_NEAREST_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  onir_pkg::in_item_t           item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output onir_pkg::out_item_t          result,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [onir_pkg::CFG_W-1:0]   cfg_data
);

    localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
    localparam int CMP_W = (CNT_W > onir_pkg::COUNT_W) ? CNT_W : onir_pkg::COUNT_W;
    localparam int K_W   = $clog2(KEEP_NEAREST + 1);
    localparam int KI_W  = (KEEP_NEAREST > 1) ? $clog2(KEEP_NEAREST) : 1;
    localparam int CW    = onir_pkg::COORD_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LIMIT = 3'd1;
    localparam logic [2:0] ST_MULX  = 3'd2;
    localparam logic [2:0] ST_MULY  = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           i_reg, i_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [K_W-1:0]             k_reg, k_next;
    logic [CW-1:0]              radius_reg;
    logic [onir_pkg::COUNT_W-1:0] count_reg;
    logic signed [CW-1:0]       px_reg, py_reg;
    logic                       result_valid_reg, result_valid_next;
    onir_pkg::out_item_t        result_reg, result_next;

    logic                       take_item;
    logic                       take_query;
    logic [CMP_W-1:0]           count_ext;
    logic [CNT_W-1:0]           i_inc;
    logic                       tbl_wr_en;
    logic [IDX_W-1:0]           tbl_wr_addr;
    onir_pkg::entry_t           tbl_wr_data;
    logic                       tbl_rd_en;
    logic [IDX_W-1:0]           tbl_rd_addr;
    onir_pkg::entry_t           tbl_rd_data;
    onir_pkg::du_ctrl_t         du_ctrl;
    logic [onir_pkg::PROD_W-1:0] limit;
    logic [onir_pkg::DIST_W-1:0] dist_sq;
    onir_pkg::cand_t            cand;
    logic                       rank_insert;
    onir_pkg::cand_t            best [KEEP_NEAREST];
    logic [IDX_W-1:0]           best_idx [KEEP_NEAREST];
    logic [KEEP_NEAREST-1:0]    best_valid;
    logic [K_W-1:0]             nvalid;
    logic [KI_W-1:0]            ksel;
    logic                       emit_last;
    logic                       out_free;

    assign item_stall   = (state_reg != ST_IDLE);
    assign take_item    = item_valid && !item_stall;
    assign take_query   = take_item && (item.operation == onir_pkg::OP_QUERY);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= CW'(1280);
            count_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                onir_pkg::REG_SEARCH_RADIUS:  radius_reg <= cfg_data;
                onir_pkg::REG_OBSTACLE_COUNT: count_reg  <= cfg_data[onir_pkg::COUNT_W-1:0];
                default:                      radius_reg <= radius_reg;
            endcase
        end
    end

    // table write on load
    assign tbl_wr_en   = take_item && (item.operation == onir_pkg::OP_LOAD) &&
                         (CMP_W'(item.entry_index) < CMP_W'(MAX_OBSTACLES));
    assign tbl_wr_addr = IDX_W'(item.entry_index);
    assign tbl_wr_data = '{x: item.obstacle_x, y: item.obstacle_y,
                           radius: item.obstacle_radius};

    assign i_inc       = i_reg + CNT_W'(1);
    assign tbl_rd_en   = ((state_reg == ST_LIMIT) && (n_reg != '0)) ||
                         ((state_reg == ST_CMP) && (i_inc != n_reg));
    assign tbl_rd_addr = (state_reg == ST_CMP) ? i_inc[IDX_W-1:0] : '0;

    onir_table #(
        .DEPTH (MAX_OBSTACLES),
        .AW    (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    always_comb
    begin
        du_ctrl.en   = 1'b0;
        du_ctrl.mode = onir_pkg::DU_LIMIT;
        unique case (state_reg)
            ST_LIMIT:
            begin
                du_ctrl.en   = 1'b1;
                du_ctrl.mode = onir_pkg::DU_LIMIT;
            end
            ST_MULX:
            begin
                du_ctrl.en   = 1'b1;
                du_ctrl.mode = onir_pkg::DU_X;
            end
            ST_MULY:
            begin
                du_ctrl.en   = 1'b1;
                du_ctrl.mode = onir_pkg::DU_Y;
            end
            default:
            begin
                du_ctrl.en   = 1'b0;
                du_ctrl.mode = onir_pkg::DU_LIMIT;
            end
        endcase
    end

    onir_dist_unit u_dist (
        .clk     (clk),
        .ctrl    (du_ctrl),
        .radius  (radius_reg),
        .pos_x   (px_reg),
        .pos_y   (py_reg),
        .entry   (tbl_rd_data),
        .limit   (limit),
        .dist_sq (dist_sq)
    );

    assign cand = '{dist_sq: dist_sq, x: tbl_rd_data.x, y: tbl_rd_data.y,
                    radius: tbl_rd_data.radius};
    assign rank_insert = (state_reg == ST_CMP) && (dist_sq <= {1'b0, limit});

    onir_rank #(
        .KEEP  (KEEP_NEAREST),
        .IDX_W (IDX_W)
    ) u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (take_query),
        .insert   (rank_insert),
        .cand     (cand),
        .cand_idx (i_reg[IDX_W-1:0]),
        .best     (best),
        .best_idx (best_idx),
        .valid    (best_valid)
    );

    // result selection
    always_comb
    begin
        nvalid = '0;
        for (int j = 0; j < KEEP_NEAREST; j++)
        begin
            nvalid = nvalid + K_W'(best_valid[j]);
        end
        ksel = k_reg[KI_W-1:0];
        if (nvalid == '0)
        begin
            emit_last   = 1'b1;
            result_next = '{found: 1'b0, near_id: '0, near_x: '0, near_y: '0,
                            near_radius: '0, last: 1'b1};
        end
        else
        begin
            emit_last   = (k_reg == nvalid - K_W'(1));
            result_next = '{found: 1'b1,
                            near_id: onir_pkg::ID_W'(best_idx[ksel]),
                            near_x: best[ksel].x,
                            near_y: best[ksel].y,
                            near_radius: best[ksel].radius,
                            last: emit_last};
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        result_valid_next = result_valid_reg && result_stall;
        count_ext         = CMP_W'(count_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_query)
                begin
                    n_next     = (count_ext > CMP_W'(MAX_OBSTACLES)) ?
                                 CNT_W'(MAX_OBSTACLES) : CNT_W'(count_ext);
                    i_next     = '0;
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                k_next     = '0;
                state_next = (n_reg == '0) ? ST_EMIT : ST_MULX;
            end
            ST_MULX:
            begin
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                i_next = i_inc;
                if (i_inc == n_reg)
                begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MULX;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    k_next            = k_reg + K_W'(1);
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            i_reg            <= '0;
            n_reg            <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            n_reg            <= n_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_query)
        begin
            px_reg <= item.position_x;
            py_reg <= item.position_y;
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            result_reg <= result_next;
        end
    end

    `ASSERT_NEXT(a_query_starts, clk, rst_n, take_query, state_reg == ST_LIMIT, "query transfer did not start a scan")
    `ASSERT_IMPLIES(a_scan_in_range, clk, rst_n, state_reg == ST_CMP, i_reg < n_reg, "scan index past obstacle count")
    `ASSERT_IMPLIES(a_empty_is_last, clk, rst_n, result_valid_reg && !result_reg.found, result_reg.last, "empty result not flagged last")

endmodule

FILE: verif/tb_nearest_obstacles_in_radius_core.sv
// ----------------------------------------------------------------------------
// tb_nearest_obstacles_in_radius_core
// Self-checking bench for the nearest obstacle search block. A scoreboard
// class keeps its own copy of the obstacle table and the two registers. For
// every accepted query it ranks the in-range obstacles and queues up to three
// expected results, and it checks each result transfer against them field by
// field. Directed loads and queries cover ties, coordinate extremes, a range
// exactly at the limit, a zero radius and an empty table scan. Random
// clustered traffic then runs under changing register settings and changing
// idle patterns on both channels, including one long output stall.
// ----------------------------------------------------------------------------
module tb_nearest_obstacles_in_radius_core;

    localparam int TABLE_DEPTH   = onir_pkg::MAX_OBSTACLES_DEF;
    localparam int KEEP          = onir_pkg::KEEP_NEAREST_DEF;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 7;

    typedef struct {
        longint sq_range;
        int     x;
        int     y;
        int     slot;
    } hit_t;

    class obstacle_scoreboard;
        logic [15:0]          det_radius;
        logic [6:0]           search_count;
        logic signed [15:0]   tab_x [TABLE_DEPTH];
        logic signed [15:0]   tab_y [TABLE_DEPTH];
        logic [15:0]          tab_r [TABLE_DEPTH];
        onir_pkg::out_item_t  awaited [$];
        int                   errors;
        int                   loads;
        int                   queries;
        int                   misses;
        int                   triples;
        int                   checked;

        function new();
            det_radius   = 16'd1280;
            search_count = '0;
            errors       = 0;
            loads        = 0;
            queries      = 0;
            misses       = 0;
            triples      = 0;
            checked      = 0;
        endfunction

        function void apply_reg(logic idx, logic [15:0] data);
            if (idx == onir_pkg::REG_SEARCH_RADIUS)
                det_radius = data;
            else
                search_count = data[6:0];
        endfunction

        function bit ranks_ahead(hit_t a, hit_t b);
            if (a.sq_range != b.sq_range)
                return a.sq_range < b.sq_range;
            if (a.x != b.x)
                return a.x < b.x;
            if (a.y != b.y)
                return a.y < b.y;
            return a.slot < b.slot;
        endfunction

        function void note_input(onir_pkg::in_item_t it);
            hit_t                hits [$];
            hit_t                h;
            longint              lim;
            longint              dx;
            longint              dy;
            int                  scan;
            int                  pick;
            onir_pkg::out_item_t r;

            if (it.operation == onir_pkg::OP_LOAD) begin
                tab_x[it.entry_index] = it.obstacle_x;
                tab_y[it.entry_index] = it.obstacle_y;
                tab_r[it.entry_index] = it.obstacle_radius;
                loads++;
                return;
            end
            queries++;
            lim  = longint'(det_radius) * longint'(det_radius);
            scan = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_count);
            for (int i = 0; i < scan; i++) begin
                dx         = longint'(tab_x[i]) - longint'(it.position_x);
                dy         = longint'(tab_y[i]) - longint'(it.position_y);
                h.sq_range = dx * dx + dy * dy;
                h.x        = tab_x[i];
                h.y        = tab_y[i];
                h.slot     = i;
                if (h.sq_range <= lim)
                    hits = {hits, h};
            end
            if (hits.size() == 0) begin
                r      = '0;
                r.last = 1'b1;
                awaited = {awaited, r};
                misses++;
                return;
            end
            for (int k = 0; k < KEEP && hits.size() > 0; k++) begin
                pick = 0;
                for (int j = 1; j < hits.size(); j++)
                    if (ranks_ahead(hits[j], hits[pick]))
                        pick = j;
                r.found       = 1'b1;
                r.near_id     = 6'(hits[pick].slot);
                r.near_x      = 16'(hits[pick].x);
                r.near_y      = 16'(hits[pick].y);
                r.near_radius = tab_r[hits[pick].slot];
                hits.delete(pick);
                r.last = (k == KEEP - 1) || (hits.size() == 0);
                if (k == KEEP - 1)
                    triples++;
                awaited = {awaited, r};
            end
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(onir_pkg::out_item_t got);
            onir_pkg::out_item_t want;

            if (awaited.size() == 0) begin
                $error("unexpected result transfer (found %0d, near_id %0d)",
                       got.found, got.near_id);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare_field("found", want.found, got.found);
            compare_field("near_id", want.near_id, got.near_id);
            compare_field("near_x", want.near_x, got.near_x);
            compare_field("near_y", want.near_y, got.near_y);
            compare_field("near_radius", want.near_radius, got.near_radius);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       item_valid   = 1'b0;
    logic                       item_stall;
    onir_pkg::in_item_t         item         = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    onir_pkg::out_item_t        result;
    logic                       cfg_wr_en    = 1'b0;
    logic                       cfg_index    = onir_pkg::REG_SEARCH_RADIUS;
    logic [onir_pkg::CFG_W-1:0] cfg_data     = '0;

    int                 tx_idle_pct  = 0;
    int                 rx_idle_pct  = 0;
    bit                 hold_req     = 1'b0;
    bit                 hold_done    = 1'b0;
    obstacle_scoreboard sb           = new();

    nearest_obstacles_in_radius_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // output side: random stall, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    function automatic onir_pkg::in_item_t random_fill();
        onir_pkg::in_item_t it;

        it.operation       = 1'($urandom_range(0, 1));
        it.entry_index     = 6'($urandom_range(0, TABLE_DEPTH - 1));
        it.obstacle_x      = 16'($urandom);
        it.obstacle_y      = 16'($urandom);
        it.obstacle_radius = 16'($urandom);
        it.position_x      = 16'($urandom);
        it.position_y      = 16'($urandom);
        return it;
    endfunction

    function automatic logic signed [15:0] pick_coord();
        logic signed [15:0] c;

        case ($urandom_range(0, 3))
            0:       c = 16'((int'($urandom_range(0, 8)) - 4) * 256);
            1, 2:    c = 16'(int'($urandom_range(0, 4095)) - 2048);
            default: c = 16'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [15:0] pick_radius();
        logic [15:0] r;

        case ($urandom_range(0, 5))
            0:       r = 16'd0;
            1:       r = 16'hFFFF;
            2:       r = 16'd1280;
            3, 4:    r = 16'($urandom_range(256, 4095));
            default: r = 16'($urandom_range(0, 65535));
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pick_count();
        logic [15:0] n;

        case ($urandom_range(0, 7))
            0:       n = 16'd0;
            1:       n = 16'(TABLE_DEPTH);
            2:       n = 16'd127;
            3:       n = 16'($urandom_range(TABLE_DEPTH + 1, 126));
            default: n = 16'($urandom_range(1, TABLE_DEPTH - 1));
        endcase
        return n;
    endfunction

    task automatic send_item(input onir_pkg::in_item_t it);
        int gap;

        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic load_slot(input int slot, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic [15:0] r);
        onir_pkg::in_item_t it;

        it                 = random_fill();
        it.operation       = onir_pkg::OP_LOAD;
        it.entry_index     = 6'(slot);
        it.obstacle_x      = x;
        it.obstacle_y      = y;
        it.obstacle_radius = r;
        send_item(it);
    endtask

    task automatic query_at(input logic signed [15:0] x, input logic signed [15:0] y);
        onir_pkg::in_item_t it;

        it            = random_fill();
        it.operation  = onir_pkg::OP_QUERY;
        it.position_x = x;
        it.position_y = y;
        send_item(it);
    endtask

    // drop valid and wait until every queued result has come back
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic idx, input logic [15:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.apply_reg(idx, data);
    endtask

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 26;
        rx_idle_pct = 62;

        // reset settings: empty search
        query_at(16'sd0, 16'sd0);
        // equal distances resolved by x, then y, then slot
        load_slot(0, 16'sd256, 16'sd0, 16'd100);
        load_slot(1, 16'sd0, 16'sd256, 16'd200);
        load_slot(2, 16'sd0, 16'sd256, 16'd300);
        load_slot(3, -16'sd32768, -16'sd32768, 16'd0);
        load_slot(4, 16'sd32767, 16'sd32767, 16'hFFFF);
        load_slot(5, -16'sd256, 16'sd0, 16'd7);
        load_slot(TABLE_DEPTH - 1, 16'sd100, -16'sd100, 16'h5A5A);
        settle();
        set_reg(onir_pkg::REG_OBSTACLE_COUNT, 16'd6);
        query_at(16'sd0, 16'sd0);
        query_at(-16'sd32768, -16'sd32768);
        query_at(16'sd32767, 16'sd32767);
        query_at(16'sd0, 16'sd1280);
        settle();
        set_reg(onir_pkg::REG_SEARCH_RADIUS, 16'hFFFF);
        query_at(16'sd0, 16'sd0);
        // two obstacles exactly on the range limit
        query_at(16'sd32767, -16'sd32768);
        settle();
        set_reg(onir_pkg::REG_SEARCH_RADIUS, 16'd0);
        query_at(16'sd256, 16'sd0);
        query_at(16'sd1, 16'sd0);

        for (int s = 0; s < TABLE_DEPTH; s++)
            load_slot(s, pick_coord(), pick_coord(), 16'($urandom_range(0, 65535)));
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES / 3) begin
                tx_idle_pct = 62;
                rx_idle_pct = 26;
            end
            if (ph == 2 * PHASES / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            settle();
            set_reg(onir_pkg::REG_SEARCH_RADIUS, pick_radius());
            set_reg(onir_pkg::REG_OBSTACLE_COUNT, pick_count());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == PHASES / 3 + 1 && n == 2)
                    hold_req = 1'b1;
                if ($urandom_range(0, 9) < 7)
                    query_at(pick_coord(), pick_coord());
                else
                    load_slot(int'($urandom_range(0, TABLE_DEPTH - 1)), pick_coord(),
                              pick_coord(), 16'($urandom_range(0, 65535)));
            end
        end
        settle();

        $display("summary: %0d loads and %0d queries sent, %0d results checked",
                 sb.loads, sb.queries, sb.checked);
        $display("summary: %0d queries had nothing in range, %0d reported three",
                 sb.misses, sb.triples);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/onir_pkg.sv
rtl/onir_table.sv
rtl/onir_dist_unit.sv
rtl/onir_rank.sv
rtl/nearest_obstacles_in_radius_core.sv
verif/tb_nearest_obstacles_in_radius_core.sv
